/* rtl/wtj_pkg.sv */
// ----------------------------------------------------------------------------
// wtj_pkg
// Shared widths, codes and types of the dc withstand limit judge.
// ----------------------------------------------------------------------------
package wtj_pkg;

   localparam int DATA_W      = 16;
   localparam int STAGE_W     = 2;
   localparam int FAIL_W      = 3;
   localparam int VERDICT_W   = 2;
   localparam int CSR_INDEX_W = 3;
   localparam int PROD_W      = 2 * DATA_W;
   localparam int GAIN_FRAC   = 12;
   localparam int SCALED_W    = PROD_W - GAIN_FRAC;
   localparam int VRAW_W      = SCALED_W + 2;
   localparam int THR_W       = DATA_W + 1;
   localparam int CNT_W       = 2;

   // fixed voltage offset added after scaling
   localparam int VOLTAGE_OFFSET = 0;
   localparam logic signed [VRAW_W-1:0] VOFFSET_S = VRAW_W'(VOLTAGE_OFFSET);

   // steady-stage snap window around the target
   localparam logic signed [VRAW_W-1:0] SNAP_BELOW = VRAW_W'(10);
   localparam logic signed [VRAW_W-1:0] SNAP_ABOVE = VRAW_W'(3);

   // overshoot threshold: target * 11 / 10 + 10, divide by 10 via reciprocal
   localparam int THR_MUL_W   = 20;
   localparam int DIV10_W     = 20;
   localparam int DIV10_SHIFT = 23;
   localparam logic [DIV10_W-1:0]  DIV10_MUL = DIV10_W'(838861);
   localparam logic [THR_W-1:0]    THR_ADD   = THR_W'(10);
   localparam logic [THR_MUL_W-1:0] THR_NUM  = THR_MUL_W'(11);

   localparam logic [DATA_W-1:0] SETTLE_TICKS = DATA_W'(2);
   localparam logic [DATA_W-1:0] SHORT_TICKS  = DATA_W'(5);

   localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(3);
   localparam logic [CNT_W-1:0] OV_LIMIT  = CNT_W'(3);
   localparam logic [CNT_W-1:0] UC_LIMIT  = CNT_W'(2);

   localparam logic [DATA_W-1:0] DATA_MAX = {DATA_W{1'b1}};

   typedef enum logic [STAGE_W-1:0] {
      STAGE_RAMP      = 2'd0,
      STAGE_VOLT_STEP = 2'd1,
      STAGE_STEADY    = 2'd2,
      STAGE_OTHER     = 2'd3
   } stage_type;

   typedef enum logic [FAIL_W-1:0] {
      FAIL_NONE         = 3'd0,
      FAIL_OVER_CURRENT = 3'd1,
      FAIL_UNDER_CURRENT = 3'd2,
      FAIL_VOLTAGE      = 3'd3,
      FAIL_SHORT        = 3'd4
   } fail_type;

   typedef enum logic [VERDICT_W-1:0] {
      VERDICT_PASS        = 2'd0,
      VERDICT_LOW_CURRENT = 2'd1,
      VERDICT_NO_CHARGE   = 2'd2
   } verdict_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TARGET_VOLTAGE     = 3'd0,
      CSR_TEST_DURATION      = 3'd1,
      CSR_CURRENT_HIGH_LIMIT = 3'd2,
      CSR_CURRENT_LOW_LIMIT  = 3'd3,
      CSR_CHARGE_CURRENT_MIN = 3'd4,
      CSR_CURRENT_OFFSET     = 3'd5,
      CSR_VOLTAGE_GAIN       = 3'd6,
      CSR_CURRENT_GAIN       = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [DATA_W-1:0] target_voltage;
      logic [DATA_W-1:0] test_duration;
      logic [DATA_W-1:0] current_high_limit;
      logic [DATA_W-1:0] current_low_limit;
      logic [DATA_W-1:0] charge_current_min;
      logic [DATA_W-1:0] current_offset;
      logic [DATA_W-1:0] voltage_gain;
      logic [DATA_W-1:0] current_gain;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      target_voltage:     '0,
      test_duration:      '0,
      current_high_limit: DATA_MAX,
      current_low_limit:  '0,
      charge_current_min: '0,
      current_offset:     '0,
      voltage_gain:       DATA_W'(4096),
      current_gain:       DATA_W'(4096)
   };

   // sample after the gain multiply, waiting for judging
   typedef struct packed {
      logic [PROD_W-1:0] voltage_prod;
      logic              voltage_zero;
      logic [PROD_W-1:0] current_prod;
      stage_type         test_stage;
      logic [DATA_W-1:0] elapsed_ticks;
      logic              judge_enable;
      logic              restart;
   } sample_type;

   typedef struct packed {
      logic [DATA_W-1:0] voltage_value;
      logic [DATA_W-1:0] current_value;
      fail_type          fail_code;
      verdict_type       end_verdict;
      logic              end_verdict_valid;
      logic              stop_request;
   } result_type;

endpackage

/* rtl/wtj_ifs.sv */
// ----------------------------------------------------------------------------
// wtj channel interfaces
// Valid/ready channels for samples, results and register writes.
// ----------------------------------------------------------------------------
interface wtj_req_if
   import wtj_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [DATA_W-1:0]  voltage_sample;
   logic [DATA_W-1:0]  current_sample;
   logic [STAGE_W-1:0] test_stage;
   logic [DATA_W-1:0]  elapsed_ticks;
   logic               judge_enable;
   logic               restart;

   modport source (output valid, voltage_sample, current_sample, test_stage,
                   elapsed_ticks, judge_enable, restart, input ready);
   modport sink   (input valid, voltage_sample, current_sample, test_stage,
                   elapsed_ticks, judge_enable, restart, output ready);
endinterface

interface wtj_rsp_if
   import wtj_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [DATA_W-1:0]    voltage_value;
   logic [DATA_W-1:0]    current_value;
   logic [FAIL_W-1:0]    fail_code;
   logic [VERDICT_W-1:0] end_verdict;
   logic                 end_verdict_valid;
   logic                 stop_request;

   modport source (output valid, voltage_value, current_value, fail_code,
                   end_verdict, end_verdict_valid, stop_request, input ready);
   modport sink   (input valid, voltage_value, current_value, fail_code,
                   end_verdict, end_verdict_valid, stop_request, output ready);
endinterface

interface wtj_csr_if
   import wtj_pkg::*;
   ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [DATA_W-1:0]      data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/withstand_test_limit_judge.sv */
// ----------------------------------------------------------------------------
// withstand_test_limit_judge
// Scales voltage and current samples of a dc withstand test and judges them
// against the configured limits, one result per sample.
//
//   channel  dir  handshake      content
//   req_     in   valid/ready    voltage/current samples, stage, time, flags
//   rsp_     out  valid/ready    scaled values, fail code, end verdict, stop
//   csr_     in   valid/ready    register index and write data (always ready)
//
// two register stages: the gain multiplies go into the sample register, the
// judge logic and test state update feed the result register.
// one sample per cycle sustained while rsp_ready stays high; an accepted sample passes the
// sample register and then the result register before rsp_valid. a full result register
// stalls the sample register, which stalls req_ready. synchronous reset clears the pipeline
// and the test state and sets the register file to its defaults.
module withstand_test_limit_judge
   import wtj_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   wtj_req_if.sink    req_chan,
   wtj_rsp_if.source  rsp_chan,
   wtj_csr_if.sink    csr_chan
);

   cfg_type           cfg_ff;
   logic [THR_W-1:0]  threshold_ff;
   logic [THR_MUL_W-1:0] target_x11;
   logic [THR_MUL_W+DIV10_W-1:0] thr_prod;

   sample_type        sample_ff;
   logic              sample_valid_ff;
   result_type        result_ff, result_in;
   logic              result_valid_ff;

   logic              req_accept, result_load;

   // ---- register file ----
   assign csr_chan.ready = 1'b1;

   // threshold derived from the written target: x * 11 / 10 + 10
   assign target_x11 = {{(THR_MUL_W-DATA_W){1'b0}}, csr_chan.data} * THR_NUM;
   assign thr_prod   = {{DIV10_W{1'b0}}, target_x11} * {{THR_MUL_W{1'b0}}, DIV10_MUL};

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= CFG_RESET;
         threshold_ff <= THR_ADD;
      end else if (csr_chan.valid) begin
         unique case (csr_index_type'(csr_chan.index))
            CSR_TARGET_VOLTAGE: begin
               cfg_ff.target_voltage <= csr_chan.data;
               threshold_ff <= thr_prod[DIV10_SHIFT +: THR_W] + THR_ADD;
            end
            CSR_TEST_DURATION:      cfg_ff.test_duration      <= csr_chan.data;
            CSR_CURRENT_HIGH_LIMIT: cfg_ff.current_high_limit <= csr_chan.data;
            CSR_CURRENT_LOW_LIMIT:  cfg_ff.current_low_limit  <= csr_chan.data;
            CSR_CHARGE_CURRENT_MIN: cfg_ff.charge_current_min <= csr_chan.data;
            CSR_CURRENT_OFFSET:     cfg_ff.current_offset     <= csr_chan.data;
            CSR_VOLTAGE_GAIN:       cfg_ff.voltage_gain       <= csr_chan.data;
            CSR_CURRENT_GAIN:       cfg_ff.current_gain       <= csr_chan.data;
            default: ;
         endcase
      end
   end

   // ---- pipeline control ----
   assign result_load    = sample_valid_ff && (!result_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !sample_valid_ff || result_load;
   assign req_accept     = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_valid_ff <= 1'b0;
         result_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            sample_valid_ff <= 1'b1;
         end else if (result_load) begin
            sample_valid_ff <= 1'b0;
         end
         if (result_load) begin
            result_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            result_valid_ff <= 1'b0;
         end
      end
   end

   // sample register with the gain multiplies
   always_ff @(posedge clock) begin
      if (req_accept) begin
         sample_ff.voltage_prod  <= PROD_W'(req_chan.voltage_sample) *
                                    PROD_W'(cfg_ff.voltage_gain);
         sample_ff.voltage_zero  <= (req_chan.voltage_sample == '0);
         sample_ff.current_prod  <= PROD_W'(req_chan.current_sample) *
                                    PROD_W'(cfg_ff.current_gain);
         sample_ff.test_stage    <= stage_type'(req_chan.test_stage);
         sample_ff.elapsed_ticks <= req_chan.elapsed_ticks;
         sample_ff.judge_enable  <= req_chan.judge_enable;
         sample_ff.restart       <= req_chan.restart;
      end
   end

   wtj_judge u_judge (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .threshold (threshold_ff),
      .sample    (sample_ff),
      .advance   (result_load),
      .result    (result_in)
   );

   always_ff @(posedge clock) begin
      if (result_load) begin
         result_ff <= result_in;
      end
   end

   assign rsp_chan.valid             = result_valid_ff;
   assign rsp_chan.voltage_value     = result_ff.voltage_value;
   assign rsp_chan.current_value     = result_ff.current_value;
   assign rsp_chan.fail_code         = result_ff.fail_code;
   assign rsp_chan.end_verdict       = result_ff.end_verdict;
   assign rsp_chan.end_verdict_valid = result_ff.end_verdict_valid;
   assign rsp_chan.stop_request      = result_ff.stop_request;

   // ---- checks ----
   assert property (@(posedge clock) disable iff (reset)
      result_valid_ff && result_ff.fail_code != FAIL_NONE |-> result_ff.stop_request)
      else $error("failure reported without stop request");

   assert property (@(posedge clock) disable iff (reset)
      result_valid_ff && result_ff.end_verdict_valid |->
         result_ff.fail_code == FAIL_NONE)
      else $error("end verdict given together with a failure");

   assert property (@(posedge clock) disable iff (reset)
      result_valid_ff && !result_ff.end_verdict_valid |->
         result_ff.end_verdict == VERDICT_PASS)
      else $error("end verdict nonzero without verdict valid");

   assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> sample_valid_ff && result_valid_ff && !rsp_chan.ready)
      else $error("input stalled with room in the pipeline");

endmodule

/* rtl/wtj_judge.sv */
// ----------------------------------------------------------------------------
// wtj_judge
// Scaling, snapping and failure judging of one sample; holds the test state.
// ----------------------------------------------------------------------------
module wtj_judge
   import wtj_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic [THR_W-1:0]  threshold,
   input  sample_type        sample,
   input  logic              advance,
   output result_type        result
);

   logic [CNT_W-1:0] overvolt_count_ff, overvolt_count_in;
   logic [CNT_W-1:0] undercurrent_count_ff, undercurrent_count_in;
   logic             charge_pending_ff, charge_pending_in;
   logic             judging_halted_ff, judging_halted_in;

   logic [CNT_W-1:0] ov_cur, uc_cur;
   logic             cp_cur, halt_cur;

   logic [SCALED_W-1:0]      v_scaled, c_scaled, c_diff;
   logic signed [VRAW_W-1:0] v_raw, v_snap, target_s;
   logic [DATA_W-1:0]        volt, curr;
   logic                     near_end;
   fail_type                 err;
   verdict_type              verdict;
   logic                     verdict_valid;

   always_comb begin
      // restart clears the test state ahead of this sample
      ov_cur   = sample.restart ? '0 : overvolt_count_ff;
      uc_cur   = sample.restart ? '0 : undercurrent_count_ff;
      cp_cur   = sample.restart ? 1'b1 : charge_pending_ff;
      halt_cur = sample.restart ? 1'b0 : judging_halted_ff;

      // voltage: scale, offset, snap to target in steady stage, clamp
      v_scaled = sample.voltage_prod[PROD_W-1:GAIN_FRAC];
      target_s = $signed({{(VRAW_W-DATA_W){1'b0}}, cfg.target_voltage});
      v_raw = sample.voltage_zero ? '0 :
              $signed({{(VRAW_W-SCALED_W){1'b0}}, v_scaled}) + VOFFSET_S;
      v_snap = v_raw;
      if (sample.test_stage == STAGE_STEADY) begin
         if (v_raw <= target_s) begin
            if (v_raw + SNAP_BELOW > target_s) v_snap = target_s;
         end else if (target_s + SNAP_ABOVE > v_raw) begin
            v_snap = target_s;
         end
      end
      if (v_snap[VRAW_W-1]) begin
         volt = '0;
      end else if (|v_snap[VRAW_W-1:DATA_W]) begin
         volt = DATA_MAX;
      end else begin
         volt = v_snap[DATA_W-1:0];
      end

      // current: scale, remove offset with floor at zero, saturate
      c_scaled = sample.current_prod[PROD_W-1:GAIN_FRAC];
      if (c_scaled >= {{(SCALED_W-DATA_W){1'b0}}, cfg.current_offset}) begin
         c_diff = c_scaled - {{(SCALED_W-DATA_W){1'b0}}, cfg.current_offset};
      end else begin
         c_diff = '0;
      end
      curr = (|c_diff[SCALED_W-1:DATA_W]) ? DATA_MAX : c_diff[DATA_W-1:0];

      near_end = (cfg.test_duration != '0) &&
                 ({1'b0, sample.elapsed_ticks} + 17'd1 >= {1'b0, cfg.test_duration});

      overvolt_count_in     = ov_cur;
      undercurrent_count_in = uc_cur;
      charge_pending_in     = cp_cur;
      judging_halted_in     = halt_cur;
      err                   = FAIL_NONE;
      verdict               = VERDICT_PASS;
      verdict_valid         = 1'b0;

      if (sample.judge_enable && !halt_cur) begin
         if (curr > cfg.charge_current_min || cfg.charge_current_min == '0) begin
            charge_pending_in = 1'b0;
         end

         if (curr > cfg.current_high_limit) begin
            err = FAIL_OVER_CURRENT;
         end else if (sample.test_stage == STAGE_RAMP ||
                      sample.test_stage == STAGE_VOLT_STEP) begin
            // overshoot must persist before it counts
            if ({1'b0, volt} > threshold) begin
               if (ov_cur != CNT_MAX) overvolt_count_in = ov_cur + CNT_W'(1);
               if (overvolt_count_in == OV_LIMIT) err = FAIL_VOLTAGE;
            end else begin
               overvolt_count_in = '0;
            end
         end else if (sample.test_stage == STAGE_STEADY &&
                      sample.elapsed_ticks > SETTLE_TICKS) begin
            if ((sample.elapsed_ticks >= SHORT_TICKS ||
                 sample.elapsed_ticks == cfg.test_duration) && volt == '0) begin
               err = FAIL_SHORT;
            end else if (!near_end && (volt < (cfg.target_voltage >> 1) ||
                                       {1'b0, volt} > threshold)) begin
               err = FAIL_VOLTAGE;
            end

            if (err == FAIL_NONE) begin
               if (curr < cfg.current_low_limit) begin
                  if (uc_cur != CNT_MAX) undercurrent_count_in = uc_cur + CNT_W'(1);
                  if (undercurrent_count_in >= UC_LIMIT) err = FAIL_UNDER_CURRENT;
               end else begin
                  undercurrent_count_in = '0;
               end
            end

            if (err == FAIL_NONE && near_end) begin
               verdict_valid = 1'b1;
               if (curr < cfg.current_low_limit) begin
                  verdict = VERDICT_LOW_CURRENT;
               end else if (charge_pending_in) begin
                  verdict = VERDICT_NO_CHARGE;
               end
            end
         end

         if (err != FAIL_NONE) judging_halted_in = 1'b1;
      end

      result.voltage_value     = volt;
      result.current_value     = curr;
      result.fail_code         = err;
      result.end_verdict       = verdict;
      result.end_verdict_valid = verdict_valid;
      result.stop_request      = judging_halted_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         overvolt_count_ff     <= '0;
         undercurrent_count_ff <= '0;
         charge_pending_ff     <= 1'b1;
         judging_halted_ff     <= 1'b0;
      end else if (advance) begin
         overvolt_count_ff     <= overvolt_count_in;
         undercurrent_count_ff <= undercurrent_count_in;
         charge_pending_ff     <= charge_pending_in;
         judging_halted_ff     <= judging_halted_in;
      end
   end

   // a halted test never counts further
   assert property (@(posedge clock) disable iff (reset)
      judging_halted_ff && advance && !sample.restart |=>
         $stable(overvolt_count_ff) && $stable(undercurrent_count_ff))
      else $error("test state changed while judging halted");

   // voltage abnormal during ramp or voltage step only after the overshoot count is full
   assert property (@(posedge clock) disable iff (reset)
      advance && err == FAIL_VOLTAGE && sample.test_stage != STAGE_STEADY
      |=> overvolt_count_ff == OV_LIMIT)
      else $error("ramp overshoot reported before count was full");

endmodule
